@@ src/mfr_pkg.sv @@
`default_nettype none

package mfr_pkg;

    localparam int MAX_DIM   = 128;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int DIMC_W    = $clog2(MAX_DIM + 1);
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int TOT_W     = ADDR_W + 1;
    localparam int CNT_W     = $clog2(ADDR_W);
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 7;
    localparam int OP_W      = 3;
    localparam int XF_W      = 3;

    // Bits of the transform code.
    localparam int T_SWAP = 2;
    localparam int T_FI   = 1;
    localparam int T_FJ   = 0;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 3'd0,
        OP_FLIP_ROWS = 3'd1,
        OP_FLIP_COLS = 3'd2,
        OP_ROT90     = 3'd3,
        OP_ROT180    = 3'd4,
        OP_ROT270    = 3'd5,
        OP_READ      = 3'd6
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    function automatic logic [DIMC_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIMC_W-1:0] res;
        if (d == '0) begin
            res = DIMC_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            res = DIMC_W'(MAX_DIM);
        end else begin
            res = DIMC_W'(d);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/matrix_flip_rotate_engine_core.sv @@
`default_nettype none

// Loads, flips and rotations leave busy low, so such commands can follow one
// another on every clock. A read raises busy after its start and keeps it high
// through address computation, the registered memory read, then the result cycle
// with o_strobe. The first read after a rows or cols write whose read position is
// not zero first maps that position to a row and column with a restoring divider
// before address computation. The receiver cannot stall: every result is shown
// for exactly one cycle, and the transfer happens at its end.

module matrix_flip_rotate_engine_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic        [mfr_pkg::OP_W-1:0]      i_opcode,
    input  wire logic signed [mfr_pkg::VAL_W-1:0]     i_value,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [mfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [mfr_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                      o_strobe,
    output logic signed      [mfr_pkg::VAL_W-1:0]     o_value_res,
    output logic             [mfr_pkg::IDX_W-1:0]     o_row,
    output logic             [mfr_pkg::IDX_W-1:0]     o_col,
    output logic                                      o_end_of_row,
    output logic                                      o_last
);

    import mfr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ADDR = 5'b00100,
        S_MEM  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_rows, n_rows;
    logic [CFG_W-1:0]    r_cols, n_cols;
    logic [XF_W-1:0]     r_xf, n_xf;
    logic [ADDR_W-1:0]   r_ld_pos, n_ld_pos;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [DIM_W-1:0]    r_row, n_row;
    logic [DIM_W-1:0]    r_col, n_col;
    logic                r_rc_ok, n_rc_ok;
    logic [ADDR_W-1:0]   r_div_q, n_div_q;
    logic [DIMC_W-1:0]   r_div_rem, n_div_rem;
    logic [CNT_W-1:0]    r_div_cnt, n_div_cnt;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_eor, n_eor;
    logic                r_last, n_last;

    logic [DIMC_W-1:0]        w_nr, w_nc, w_oc;
    logic [TOT_W-1:0]         w_total;
    logic                     w_swap;
    logic                     w_accept;
    logic [ADDR_W-1:0]        w_ld_eff, w_pos_eff;
    logic [TOT_W-1:0]         w_ld_inc;
    logic                     w_wr_en;
    logic [DIMC_W:0]          w_rem_sh, w_rem_sub;
    logic                     w_ge;
    logic [ADDR_W-1:0]        w_q_next;
    logic [DIM_W-1:0]         w_src_i, w_src_j, w_i, w_j;
    logic [DIM_W+DIMC_W-1:0]  w_addr_full;
    logic [VAL_W-1:0]         w_rd_data;

    assign w_nr     = clamp_dim(r_rows);
    assign w_nc     = clamp_dim(r_cols);
    assign w_total  = TOT_W'(w_nr) * TOT_W'(w_nc);
    assign w_swap   = r_xf[T_SWAP];
    assign w_oc     = w_swap ? w_nr : w_nc;
    assign w_accept = start && !busy;

    assign w_ld_eff  = (TOT_W'(r_ld_pos) >= w_total) ? '0 : r_ld_pos;
    assign w_ld_inc  = TOT_W'(w_ld_eff) + TOT_W'(1);
    assign w_pos_eff = (TOT_W'(r_pos) >= w_total) ? '0 : r_pos;

    assign w_rem_sh  = {r_div_rem, r_div_q[ADDR_W-1]};
    assign w_rem_sub = w_rem_sh - (DIMC_W + 1)'(w_oc);
    assign w_ge      = w_rem_sh >= (DIMC_W + 1)'(w_oc);
    assign w_q_next  = {r_div_q[ADDR_W-2:0], w_ge};

    assign w_src_i = w_swap ? r_col : r_row;
    assign w_src_j = w_swap ? r_row : r_col;
    assign w_i = r_xf[T_FI] ? DIM_W'(w_nr - DIMC_W'(1) - DIMC_W'(w_src_i)) : w_src_i;
    assign w_j = r_xf[T_FJ] ? DIM_W'(w_nc - DIMC_W'(1) - DIMC_W'(w_src_j)) : w_src_j;
    assign w_addr_full = (DIM_W + DIMC_W)'(w_i) * (DIM_W + DIMC_W)'(w_nc)
                       + (DIM_W + DIMC_W)'(w_j);

    assign w_wr_en = w_accept && (t_opcode'(i_opcode) == OP_LOAD);

    always_comb begin
        n_state   = r_state;
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_xf      = r_xf;
        n_ld_pos  = r_ld_pos;
        n_pos     = r_pos;
        n_row     = r_row;
        n_col     = r_col;
        n_rc_ok   = r_rc_ok;
        n_div_q   = r_div_q;
        n_div_rem = r_div_rem;
        n_div_cnt = r_div_cnt;
        n_addr    = r_addr;
        n_eor     = r_eor;
        n_last    = r_last;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS: n_rows = i_cfg_data;
                CFG_COLS: n_cols = i_cfg_data;
                default: ;
            endcase
            n_rc_ok = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_LOAD: begin
                            if (w_ld_eff == '0) begin
                                n_xf    = '0;
                                n_pos   = '0;
                                n_row   = '0;
                                n_col   = '0;
                                n_rc_ok = 1'b1;
                            end
                            n_ld_pos = (w_ld_inc >= w_total) ? '0 : ADDR_W'(w_ld_inc);
                        end
                        OP_FLIP_ROWS, OP_FLIP_COLS, OP_ROT90, OP_ROT180, OP_ROT270: begin
                            unique case (t_opcode'(i_opcode))
                                OP_FLIP_ROWS: begin
                                    if (w_swap) begin
                                        n_xf[T_FJ] = ~r_xf[T_FJ];
                                    end else begin
                                        n_xf[T_FI] = ~r_xf[T_FI];
                                    end
                                end
                                OP_FLIP_COLS: begin
                                    if (w_swap) begin
                                        n_xf[T_FI] = ~r_xf[T_FI];
                                    end else begin
                                        n_xf[T_FJ] = ~r_xf[T_FJ];
                                    end
                                end
                                OP_ROT90: begin
                                    n_xf[T_SWAP] = ~w_swap;
                                    if (w_swap) begin
                                        n_xf[T_FJ] = ~r_xf[T_FJ];
                                    end else begin
                                        n_xf[T_FI] = ~r_xf[T_FI];
                                    end
                                end
                                OP_ROT270: begin
                                    n_xf[T_SWAP] = ~w_swap;
                                    if (w_swap) begin
                                        n_xf[T_FI] = ~r_xf[T_FI];
                                    end else begin
                                        n_xf[T_FJ] = ~r_xf[T_FJ];
                                    end
                                end
                                default: begin
                                    n_xf[T_FI] = ~r_xf[T_FI];
                                    n_xf[T_FJ] = ~r_xf[T_FJ];
                                end
                            endcase
                            n_pos   = '0;
                            n_row   = '0;
                            n_col   = '0;
                            n_rc_ok = 1'b1;
                        end
                        OP_READ: begin
                            if (r_rc_ok) begin
                                n_state = S_ADDR;
                            end else if (w_pos_eff == '0) begin
                                n_pos   = '0;
                                n_row   = '0;
                                n_col   = '0;
                                n_rc_ok = 1'b1;
                                n_state = S_ADDR;
                            end else begin
                                n_pos     = w_pos_eff;
                                n_div_q   = w_pos_eff;
                                n_div_rem = '0;
                                n_div_cnt = CNT_W'(ADDR_W - 1);
                                n_state   = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_div_q   = w_q_next;
                n_div_rem = w_ge ? DIMC_W'(w_rem_sub) : DIMC_W'(w_rem_sh);
                n_div_cnt = r_div_cnt - CNT_W'(1);
                if (r_div_cnt == '0) begin
                    n_row   = DIM_W'(w_q_next);
                    n_col   = w_ge ? DIM_W'(w_rem_sub) : DIM_W'(w_rem_sh);
                    n_rc_ok = 1'b1;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_addr  = ADDR_W'(w_addr_full);
                n_eor   = (DIMC_W'(r_col) + DIMC_W'(1)) == w_oc;
                n_last  = (TOT_W'(r_pos) + TOT_W'(1)) == w_total;
                n_state = S_MEM;
            end
            S_MEM: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_last) begin
                    n_pos = '0;
                    n_row = '0;
                    n_col = '0;
                end else begin
                    n_pos = r_pos + ADDR_W'(1);
                    if (r_eor) begin
                        n_row = r_row + DIM_W'(1);
                        n_col = '0;
                    end else begin
                        n_col = r_col + DIM_W'(1);
                    end
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rows   <= CFG_W'(1);
            r_cols   <= CFG_W'(1);
            r_xf     <= '0;
            r_ld_pos <= '0;
            r_pos    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_rc_ok  <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_rows   <= n_rows;
            r_cols   <= n_cols;
            r_xf     <= n_xf;
            r_ld_pos <= n_ld_pos;
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_rc_ok  <= n_rc_ok;
        end
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
        r_div_cnt <= n_div_cnt;
        r_addr    <= n_addr;
        r_eor     <= n_eor;
        r_last    <= n_last;
    end

    mfr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_ld_eff),
        .i_wr_data (VAL_W'(unsigned'(i_value))),
        .i_rd_en   (r_state == S_MEM),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = (r_state == S_OUT);
    assign o_value_res  = signed'(w_rd_data);
    assign o_row        = IDX_W'(r_row);
    assign o_col        = IDX_W'(r_col);
    assign o_end_of_row = r_eor;
    assign o_last       = r_last;

endmodule

`default_nettype wire

@@ src/mfr_ram.sv @@
`default_nettype none

module mfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/mfr_checker.sv @@
`default_nettype none

module mfr_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic        [mfr_pkg::OP_W-1:0]      i_opcode,
    input wire logic                                 o_strobe,
    input wire logic                                 o_end_of_row,
    input wire logic                                 o_last
);

    import mfr_pkg::*;

    // A result only appears while a read is in flight.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a read");

    // Each read gives a single result.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // Commands other than a read complete in the cycle they are taken.
    a_quick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_opcode'(i_opcode) != OP_READ)) |=> !busy)
        else $error("non-read command raised busy");

    // A read command keeps the block busy in the following cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_opcode'(i_opcode) == OP_READ)) |=> busy)
        else $error("read command did not raise busy");

    // The final element of the matrix always closes a row.
    a_last_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> o_end_of_row)
        else $error("last element does not end a row");

endmodule

bind matrix_flip_rotate_engine_core mfr_checker u_mfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_opcode     (i_opcode),
    .o_strobe     (o_strobe),
    .o_end_of_row (o_end_of_row),
    .o_last       (o_last)
);

`default_nettype wire
